// ===== hw/rtl/skdmc_pkg.sv =====
// Package for the string-keyed direct-mapped cache: codes, states, defaults and constants.
`timescale 1ns / 1ps

package skdmc_pkg;

    localparam int CACHE_ENTRIES_DEF = 4096;
    localparam int MAX_PATH_LEN_DEF  = 256;

    // Hash step: seed = 3 * seed + 13 * byte, kept to 16 bits.
    localparam int HASH_W   = 16;
    localparam int HASH_MUL = 3;
    localparam int BYTE_MUL = 13;

    localparam int INODE_W  = 32;
    localparam int INDEX_W  = 12;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;
    localparam int S_TUSER_W = 2;
    localparam int M_TUSER_W = 3;

    typedef enum logic [1:0] {
        FUNC_LOOKUP  = 2'd0,
        FUNC_REPLACE = 2'd1,
        FUNC_INVAL   = 2'd2
    } func_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_META,
        S_LEN,
        S_WALK,
        S_DRAIN,
        S_FIN
    } state_t;

endpackage

// ===== hw/rtl/string_keyed_direct_mapped_cache.sv =====
// Top level of the string-keyed direct-mapped cache.
`timescale 1ns / 1ps

// A path arrives one byte per beat and is taken at one beat per cycle while it is
// being collected; every beat with a valid nonzero byte that still fits in the path
// updates a 16-bit running hash whose low bits select one entry of a direct-mapped
// table. The beat with tlast closes the path and starts the operation: S_META and
// S_LEN read the selected entry's key length and inode from the entry memory, then a
// walk over the key store compares (and, for replace, copies) one byte per cycle,
// S_DRAIN finishes the last compare, and S_FIN writes the entry (for a replace or
// an invalidate that hits) and loads the result once the output register is free
// or being read. The walk is skipped for an empty path, or for a lookup or
// invalidate whose stored key length differs. The next path is taken once the
// result has entered the output register. A too-long path goes straight to S_FIN
// and is answered without touching the table. After reset the entry memory is
// cleared one entry per cycle, so no beat is taken until every entry is cleared.
module string_keyed_direct_mapped_cache #(
    parameter int CACHE_ENTRIES = skdmc_pkg::CACHE_ENTRIES_DEF,
    parameter int MAX_PATH_LEN  = skdmc_pkg::MAX_PATH_LEN_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // path_byte [7:0], byte_valid [8], new_inode [40:9], zeros above
    input  logic [skdmc_pkg::S_TDATA_W-1:0]   s_tdata,
    // func [1:0]
    input  logic [skdmc_pkg::S_TUSER_W-1:0]   s_tuser,
    input  logic                              s_tlast,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // found [0], inode_out [32:1], entry_index [44:33], zeros above
    output logic [skdmc_pkg::M_TDATA_W-1:0]   m_tdata,
    // done_func [1:0], too_long [2]
    output logic [skdmc_pkg::M_TUSER_W-1:0]   m_tuser
);

    localparam int EW = $clog2(CACHE_ENTRIES);
    localparam int PW = (MAX_PATH_LEN > 1) ? $clog2(MAX_PATH_LEN) : 1;
    localparam int CW = $clog2(MAX_PATH_LEN + 1);
    localparam int KEY_DEPTH = CACHE_ENTRIES * (2 ** PW);
    localparam int MW = CW + skdmc_pkg::INODE_W;
    localparam int HW = skdmc_pkg::HASH_W;
    localparam int IW = skdmc_pkg::INODE_W;

    // Memories
    logic [7:0]    path_mem [MAX_PATH_LEN];
    logic [7:0]    key_mem  [KEY_DEPTH];
    logic [MW-1:0] meta_mem [CACHE_ENTRIES];

    skdmc_pkg::state_t state_reg, state_next;
    logic [EW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0]      path_count_reg, path_count_next;
    logic               ovf_reg, ovf_next;
    logic [HW-1:0]      seed_reg, seed_next;
    skdmc_pkg::func_t   func_reg, func_next;
    logic [IW-1:0]      new_inode_reg, new_inode_next;
    logic [CW-1:0]      walk_cnt_reg, walk_cnt_next;
    logic               cmp_vld_reg, cmp_vld_next;
    logic [PW-1:0]      cmp_idx_reg, cmp_idx_next;
    logic               match_reg, match_next;
    logic [IW-1:0]      stored_inode_reg, stored_inode_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_found_reg, out_found_next;
    logic [IW-1:0]      out_inode_reg, out_inode_next;
    logic [skdmc_pkg::INDEX_W-1:0] out_entry_reg, out_entry_next;
    skdmc_pkg::func_t   out_func_reg, out_func_next;
    logic               out_too_long_reg, out_too_long_next;

    logic [7:0]    pb_rd_reg;
    logic [7:0]    ks_rd_reg;
    logic [MW-1:0] meta_rd_reg;

    logic               accept;
    logic [7:0]         in_byte;
    logic               byte_take;
    skdmc_pkg::func_t   in_func;
    logic               pb_we;
    logic               ks_we;
    logic               meta_we;
    logic [EW-1:0]      meta_wa;
    logic [MW-1:0]      meta_wd;
    logic [EW-1:0]      entry;
    logic [HW-1:0]      entry_masked;
    logic [PW-1:0]      rd_idx;
    logic [CW-1:0]      stored_len;
    logic               fin_go;

    assign accept    = s_tvalid && s_tready;
    assign in_byte   = s_tdata[7:0];
    assign byte_take = s_tdata[8] && (in_byte != 8'd0);
    assign entry     = seed_reg[EW-1:0];
    assign entry_masked = seed_reg & HW'(CACHE_ENTRIES - 1);
    assign rd_idx    = walk_cnt_reg[PW-1:0];
    assign stored_len = meta_rd_reg[MW-1:IW];
    assign fin_go    = (state_reg == skdmc_pkg::S_FIN) && (!out_valid_reg || m_tready);

    assign s_tready = (state_reg == skdmc_pkg::S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_entry_reg, out_inode_reg, out_found_reg};
    assign m_tuser  = {out_too_long_reg, out_func_reg};

    // Operation code three behaves as a lookup.
    always_comb
    begin
        case (s_tuser[1:0])
            skdmc_pkg::FUNC_REPLACE: in_func = skdmc_pkg::FUNC_REPLACE;
            skdmc_pkg::FUNC_INVAL:   in_func = skdmc_pkg::FUNC_INVAL;
            default:                 in_func = skdmc_pkg::FUNC_LOOKUP;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        path_count_next   = path_count_reg;
        ovf_next          = ovf_reg;
        seed_next         = seed_reg;
        func_next         = func_reg;
        new_inode_next    = new_inode_reg;
        walk_cnt_next     = walk_cnt_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        match_next        = match_reg;
        stored_inode_next = stored_inode_reg;
        out_valid_next    = out_valid_reg && !m_tready;
        out_found_next    = out_found_reg;
        out_inode_next    = out_inode_reg;
        out_entry_next    = out_entry_reg;
        out_func_next     = out_func_reg;
        out_too_long_next = out_too_long_reg;
        pb_we             = 1'b0;
        ks_we             = 1'b0;
        meta_we           = 1'b0;
        meta_wa           = entry;
        meta_wd           = '0;

        // A compare beat: the path byte and the stored key byte read last cycle.
        if (cmp_vld_reg)
        begin
            match_next = match_reg && (pb_rd_reg == ks_rd_reg);
            ks_we      = (func_reg == skdmc_pkg::FUNC_REPLACE);
        end

        case (state_reg)
            skdmc_pkg::S_CLEAR:
            begin
                meta_we      = 1'b1;
                meta_wa      = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + EW'(1);
                if (clr_cnt_reg == EW'(CACHE_ENTRIES - 1))
                begin
                    state_next = skdmc_pkg::S_IDLE;
                end
            end
            skdmc_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (byte_take)
                    begin
                        if (path_count_reg < CW'(MAX_PATH_LEN))
                        begin
                            pb_we           = 1'b1;
                            path_count_next = path_count_reg + CW'(1);
                            seed_next       = HW'(skdmc_pkg::HASH_MUL * seed_reg)
                                            + HW'(skdmc_pkg::BYTE_MUL * in_byte);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (s_tlast)
                    begin
                        func_next      = in_func;
                        new_inode_next = s_tdata[40:9];
                        walk_cnt_next  = '0;
                        if (ovf_next)
                        begin
                            state_next = skdmc_pkg::S_FIN;
                        end
                        else
                        begin
                            state_next = skdmc_pkg::S_META;
                        end
                    end
                end
            end
            skdmc_pkg::S_META:
            begin
                // Entry memory read is under way.
                state_next = skdmc_pkg::S_LEN;
            end
            skdmc_pkg::S_LEN:
            begin
                match_next        = (stored_len == path_count_reg);
                stored_inode_next = meta_rd_reg[IW-1:0];
                if ((path_count_reg != '0) &&
                    ((func_reg == skdmc_pkg::FUNC_REPLACE) || (stored_len == path_count_reg)))
                begin
                    state_next = skdmc_pkg::S_WALK;
                end
                else
                begin
                    state_next = skdmc_pkg::S_FIN;
                end
            end
            skdmc_pkg::S_WALK:
            begin
                cmp_vld_next  = 1'b1;
                cmp_idx_next  = rd_idx;
                walk_cnt_next = walk_cnt_reg + CW'(1);
                if ((walk_cnt_reg + CW'(1)) == path_count_reg)
                begin
                    state_next = skdmc_pkg::S_DRAIN;
                end
            end
            skdmc_pkg::S_DRAIN:
            begin
                state_next = skdmc_pkg::S_FIN;
            end
            skdmc_pkg::S_FIN:
            begin
                if (fin_go)
                begin
                    out_valid_next = 1'b1;
                    out_func_next  = func_reg;
                    if (ovf_reg)
                    begin
                        out_found_next    = 1'b0;
                        out_inode_next    = '0;
                        out_entry_next    = '0;
                        out_too_long_next = 1'b1;
                    end
                    else
                    begin
                        out_found_next    = match_reg;
                        out_inode_next    = ((func_reg == skdmc_pkg::FUNC_LOOKUP) && match_reg)
                                          ? stored_inode_reg : '0;
                        out_entry_next    = entry_masked[skdmc_pkg::INDEX_W-1:0];
                        out_too_long_next = 1'b0;
                        if (func_reg == skdmc_pkg::FUNC_REPLACE)
                        begin
                            meta_we = 1'b1;
                            meta_wd = {path_count_reg, new_inode_reg};
                        end
                        else if ((func_reg == skdmc_pkg::FUNC_INVAL) && match_reg)
                        begin
                            meta_we = 1'b1;
                        end
                    end
                    path_count_next = '0;
                    ovf_next        = 1'b0;
                    seed_next       = '0;
                    state_next      = skdmc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skdmc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= skdmc_pkg::S_CLEAR;
            clr_cnt_reg    <= '0;
            path_count_reg <= '0;
            ovf_reg        <= 1'b0;
            seed_reg       <= '0;
            walk_cnt_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            path_count_reg <= path_count_next;
            ovf_reg        <= ovf_next;
            seed_reg       <= seed_next;
            walk_cnt_reg   <= walk_cnt_next;
            cmp_vld_reg    <= cmp_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg         <= func_next;
        new_inode_reg    <= new_inode_next;
        cmp_idx_reg      <= cmp_idx_next;
        match_reg        <= match_next;
        stored_inode_reg <= stored_inode_next;
        out_found_reg    <= out_found_next;
        out_inode_reg    <= out_inode_next;
        out_entry_reg    <= out_entry_next;
        out_func_reg     <= out_func_next;
        out_too_long_reg <= out_too_long_next;
    end

    // Path buffer: written while the path is collected, read during the walk.
    always_ff @(posedge clk)
    begin
        if (pb_we)
        begin
            path_mem[path_count_reg[PW-1:0]] <= in_byte;
        end
        pb_rd_reg <= path_mem[rd_idx];
    end

    // Key store: each entry owns a row of path slots; replace writes back the path byte
    // being compared while the next one is read.
    always_ff @(posedge clk)
    begin
        if (ks_we)
        begin
            key_mem[{entry, cmp_idx_reg}] <= pb_rd_reg;
        end
        ks_rd_reg <= key_mem[{entry, rd_idx}];
    end

    // Entry memory: key length above, inode below.
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_wa] <= meta_wd;
        end
        meta_rd_reg <= meta_mem[entry];
    end

endmodule

// ===== hw/rtl/skdmc_checker.sv =====
// Port-level checker for the string-keyed direct-mapped cache, with its bind.
`timescale 1ns / 1ps

module skdmc_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [skdmc_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic [skdmc_pkg::M_TUSER_W-1:0]   m_tuser
);

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The closing beat of a path starts a table operation, so no beat follows at once.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken right after the closing beat");

    // A too-long path reports no hit, no inode and entry zero.
    a_too_long_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[2] |-> (m_tdata[44:0] == 45'd0))
        else $error("too-long result carries data");

    // Only a lookup hit returns a nonzero inode.
    a_inode_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[32:1] != 32'd0) |->
            m_tdata[0] && (m_tuser[1:0] == skdmc_pkg::FUNC_LOOKUP))
        else $error("inode returned without a lookup hit");

    // The reported operation is never the unused code.
    a_func_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser[1:0] == skdmc_pkg::FUNC_LOOKUP) ||
                     (m_tuser[1:0] == skdmc_pkg::FUNC_REPLACE) ||
                     (m_tuser[1:0] == skdmc_pkg::FUNC_INVAL))
        else $error("unused operation code reported");

endmodule

bind string_keyed_direct_mapped_cache skdmc_checker u_skdmc_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the string-keyed direct-mapped cache.
`timescale 1ns / 1ps

module tb;

    localparam int          INODE_W      = skdmc_pkg::INODE_W;
    localparam int          INDEX_W      = skdmc_pkg::INDEX_W;
    localparam int          HASH_W       = skdmc_pkg::HASH_W;
    localparam int          S_TDATA_W    = skdmc_pkg::S_TDATA_W;
    localparam int          S_TUSER_W    = skdmc_pkg::S_TUSER_W;
    localparam int          M_TDATA_W    = skdmc_pkg::M_TDATA_W;
    localparam int          M_TUSER_W    = skdmc_pkg::M_TUSER_W;
    localparam int          N_ENTRIES    = skdmc_pkg::CACHE_ENTRIES_DEF;
    localparam int          MAX_LEN      = skdmc_pkg::MAX_PATH_LEN_DEF;

    localparam int          CYCLE_LIMIT  = 600000;
    localparam int          BEAT_TARGET  = 1300;
    localparam int          LONG_HOLD    = 500;
    localparam int          DRAIN_CYCLES = 300;
    localparam int          POOL_N       = 25;
    // The unused operation code, which the block must treat as a lookup.
    localparam logic [1:0]  FUNC_UNUSED  = 2'd3;

    // One beat of a path: bit 8 is byte_valid, bits 7:0 the byte.
    typedef logic [8:0] beat_t;
    typedef beat_t path_t[$];

    typedef struct packed {
        logic               found;
        logic [INODE_W-1:0] inode;
        logic [INDEX_W-1:0] index;
        logic [1:0]         done;
        logic               too_long;
    } reply_t;

    class cache_scoreboard;
        logic [7:0]         path_bytes[$];
        logic               overflow;
        logic [HASH_W-1:0]  seed;
        logic [7:0]         keys[N_ENTRIES][$];
        logic [INODE_W-1:0] inodes[N_ENTRIES];
        reply_t             replies_due[$];
        int                 errors;
        int                 replies_seen;
        int                 hits;
        int                 over_length;
        int                 op_count[3];

        function new();
            overflow = 1'b0;
            seed     = '0;
            errors   = 0;
            replies_seen = 0;
            hits     = 0;
            over_length = 0;
            foreach (inodes[i])
                inodes[i] = '0;
            foreach (op_count[i])
                op_count[i] = 0;
        endfunction

        function bit key_equal(input int entry);
            if (keys[entry].size() != path_bytes.size())
                return 1'b0;
            foreach (path_bytes[i])
                if (keys[entry][i] != path_bytes[i])
                    return 1'b0;
            return 1'b1;
        endfunction

        // Updates the path and hash, and on the closing beat works out the reply.
        function void note_beat(input logic [1:0] f, input logic [7:0] b, input logic v,
                                input logic l, input logic [INODE_W-1:0] ino);
            reply_t r;
            int     entry;
            logic   hit;
            logic [1:0] op;
            op = (f == skdmc_pkg::FUNC_REPLACE || f == skdmc_pkg::FUNC_INVAL)
                 ? f : skdmc_pkg::FUNC_LOOKUP;
            if (v && b != 8'h00)
            begin
                if (path_bytes.size() < MAX_LEN)
                begin
                    path_bytes.push_back(b);
                    seed = HASH_W'(skdmc_pkg::HASH_MUL * int'(seed)
                                   + skdmc_pkg::BYTE_MUL * int'(b));
                end
                else
                begin
                    overflow = 1'b1;
                end
            end
            if (!l)
                return;
            r = '0;
            r.done = op;
            if (overflow)
            begin
                r.too_long = 1'b1;
                over_length++;
            end
            else
            begin
                entry = int'(seed) % N_ENTRIES;
                hit = key_equal(entry);
                r.found = hit;
                r.index = INDEX_W'(entry);
                if (op == skdmc_pkg::FUNC_LOOKUP)
                begin
                    if (hit)
                        r.inode = inodes[entry];
                end
                else if (op == skdmc_pkg::FUNC_REPLACE)
                begin
                    keys[entry] = path_bytes;
                    inodes[entry] = ino;
                end
                else if (hit)
                begin
                    keys[entry].delete();
                    inodes[entry] = '0;
                end
                if (hit)
                    hits++;
            end
            op_count[op]++;
            replies_due.push_back(r);
            path_bytes.delete();
            overflow = 1'b0;
            seed = '0;
        endfunction

        function void check_reply(input logic [M_TDATA_W-1:0] d,
                                  input logic [M_TUSER_W-1:0] u);
            reply_t got;
            reply_t want;
            got.found    = d[0];
            got.inode    = d[32:1];
            got.index    = d[44:33];
            got.done     = u[1:0];
            got.too_long = u[2];
            replies_seen++;
            if (replies_due.size() == 0)
            begin
                errors++;
                $display("%0t: reply with none due: found=%0d inode=%h index=%0d func=%0d",
                         $time, got.found, got.inode, got.index, got.done,
                         " too_long=%0d", got.too_long);
                return;
            end
            want = replies_due.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t: reply mismatch: expected found=%0d inode=%h index=%0d", $time,
                         want.found, want.inode, want.index,
                         " func=%0d too_long=%0d", want.done, want.too_long);
                $display("%0t:                 actual   found=%0d inode=%h index=%0d", $time,
                         got.found, got.inode, got.index,
                         " func=%0d too_long=%0d", got.done, got.too_long);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    cache_scoreboard sb;
    int              beats_sent = 0;
    int              paths_sent = 0;
    int              burst_left = 0;
    bit              no_gaps = 1'b0;
    logic            hold_request = 1'b0;
    logic            hold_taken;
    int              hold_left;
    int              rx_cycle;
    int              cycles = 0;
    logic [7:0]      pool[POOL_N][$];
    logic [7:0]      long_key[$];

    string_keyed_direct_mapped_cache dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver: its own stall pattern, rotating through four modes, plus one long hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            rx_cycle   <= 0;
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else
        begin
            rx_cycle <= rx_cycle + 1;
            if (hold_left != 0)
            begin
                m_tready  <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_request && !hold_taken)
            begin
                m_tready   <= 1'b0;
                hold_left  <= LONG_HOLD;
                hold_taken <= 1'b1;
            end
            else
            begin
                case ((rx_cycle / 97) % 4)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (rx_cycle % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_reply(m_tdata, m_tuser);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d replies still due",
                     cycles, sb.replies_due.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic beat_t vb(input logic [7:0] b);
        return {1'b1, b};
    endfunction

    // Sender pacing: bursts of random length, usually separated by random gaps unless no_gaps is set.
    task automatic pace();
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            if (!no_gaps && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_beat(input logic [1:0] f, input logic [7:0] b, input logic v,
                             input logic l, input logic [INODE_W-1:0] ino);
        pace();
        s_tdata  <= {7'd0, ino, v, b};
        s_tuser  <= f;
        s_tlast  <= l;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_beat(f, b, v, l, ino);
        beats_sent++;
    endtask

    // Beats before the closing one carry random operation and inode fields.
    task automatic send_path(input logic [1:0] f, input path_t p,
                             input logic [INODE_W-1:0] ino);
        logic l;
        foreach (p[i])
        begin
            l = (i == p.size() - 1);
            send_beat(l ? f : 2'($urandom_range(0, 3)), p[i][7:0], p[i][8], l,
                      l ? ino : INODE_W'($urandom));
        end
        paths_sent++;
    endtask

    // Turns key bytes into beats, sprinkling in empty beats and zero bytes.
    function automatic path_t with_noise(input logic [7:0] key[$]);
        path_t p;
        foreach (key[i])
        begin
            if ($urandom_range(0, 99) < 8)
                p.push_back({1'b0, 8'($urandom)});
            if ($urandom_range(0, 99) < 3)
                p.push_back({1'b1, 8'h00});
            p.push_back(vb(key[i]));
        end
        if (p.size() == 0)
            p.push_back({1'b0, 8'($urandom)});
        return p;
    endfunction

    function automatic logic [1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return skdmc_pkg::FUNC_LOOKUP;
        else if (r < 72)
            return skdmc_pkg::FUNC_REPLACE;
        else if (r < 94)
            return skdmc_pkg::FUNC_INVAL;
        return FUNC_UNUSED;
    endfunction

    task automatic directed_paths();
        path_t none, one5, ab, ff80, fe83, mixed;
        none  = '{{1'b0, 8'h5A}};
        one5  = '{vb(8'h05)};
        ab    = '{vb(8'h01), vb(8'h02)};
        ff80  = '{vb(8'hFF), vb(8'h80)};
        fe83  = '{vb(8'hFE), vb(8'h83)};
        mixed = '{vb(8'h01), {1'b1, 8'h00}, {1'b0, 8'hA7}, vb(8'h02)};
        // The empty path hits entry 0, which holds an empty key after reset.
        send_path(skdmc_pkg::FUNC_LOOKUP, none, $urandom);
        send_path(skdmc_pkg::FUNC_LOOKUP, one5, $urandom);
        send_path(skdmc_pkg::FUNC_REPLACE, ab, 32'hFFFF_FFFF);
        send_path(skdmc_pkg::FUNC_LOOKUP, ab, $urandom);
        // Same entry, different key length.
        send_path(skdmc_pkg::FUNC_LOOKUP, one5, $urandom);
        send_path(skdmc_pkg::FUNC_REPLACE, ff80, 32'h0000_0000);
        // Same entry and length, different bytes.
        send_path(skdmc_pkg::FUNC_LOOKUP, fe83, $urandom);
        send_path(skdmc_pkg::FUNC_INVAL, fe83, $urandom);
        send_path(skdmc_pkg::FUNC_INVAL, ff80, $urandom);
        send_path(skdmc_pkg::FUNC_LOOKUP, ff80, $urandom);
        send_path(FUNC_UNUSED, ab, $urandom);
        // Zero byte and an empty beat inside the path are both skipped.
        send_path(skdmc_pkg::FUNC_REPLACE, mixed, 32'h1234_5678);
        send_path(skdmc_pkg::FUNC_LOOKUP, ab, $urandom);
        send_path(skdmc_pkg::FUNC_REPLACE, none, 32'hA5A5_A5A5);
        send_path(skdmc_pkg::FUNC_LOOKUP, none, $urandom);
        send_path(skdmc_pkg::FUNC_INVAL, none, $urandom);
        send_path(skdmc_pkg::FUNC_LOOKUP, none, $urandom);
    endtask

    // Pool of keys in groups of three: a base, a twin with the same hash and length
    // but other bytes, and a short key; a two-byte base gets a one-byte key in its entry.
    task automatic build_pool();
        int         n;
        logic [7:0] a;
        logic [7:0] b;
        for (int g = 0; g < (POOL_N - 1) / 3; g++)
        begin
            n = ($urandom_range(0, 1) != 0) ? 2 : $urandom_range(3, 9);
            for (int k = 0; k < n - 2; k++)
                pool[3 * g + 1].push_back(8'($urandom_range(1, 255)));
            if (n == 2)
            begin
                a = 8'($urandom_range(1, 60));
                b = 8'($urandom_range(4, 70));
            end
            else
            begin
                a = 8'($urandom_range(1, 254));
                b = 8'($urandom_range(4, 255));
            end
            pool[3 * g + 1].push_back(a);
            pool[3 * g + 1].push_back(b);
            pool[3 * g + 2] = pool[3 * g + 1];
            pool[3 * g + 2][n - 2] = a + 8'd1;
            pool[3 * g + 2][n - 1] = b - 8'd3;
            if (n == 2)
                pool[3 * g + 3].push_back(8'(3 * int'(a) + int'(b)));
            else
                repeat ($urandom_range(1, 3))
                    pool[3 * g + 3].push_back(8'($urandom_range(1, 255)));
        end
    endtask

    task automatic random_paths();
        int         idx;
        logic [7:0] key[$];
        path_t      p;
        idx = 0;
        for (int k = 0; k < MAX_LEN; k++)
            long_key.push_back(8'($urandom_range(1, 255)));
        while (beats_sent < BEAT_TARGET)
        begin
            no_gaps = (idx >= 50 && idx < 65);
            if (idx == 30)
                hold_request <= 1'b1;
            key.delete();
            if (idx == 15 || idx == 16)
            begin
                // Longest key allowed: stored, then looked up again.
                send_path(idx == 15 ? skdmc_pkg::FUNC_REPLACE : skdmc_pkg::FUNC_LOOKUP,
                          with_noise(long_key), $urandom);
            end
            else if (idx == 40)
            begin
                key = long_key;
                key.push_back(8'($urandom_range(1, 255)));
                p.delete();
                foreach (key[i])
                    p.push_back(vb(key[i]));
                send_path(2'($urandom_range(0, 3)), p, $urandom);
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    key = pool[$urandom_range(0, POOL_N - 1)];
                else
                    repeat ($urandom_range(1, 12))
                        key.push_back(8'($urandom_range(1, 255)));
                send_path(pick_op(), with_noise(key), $urandom);
            end
            idx++;
        end
    endtask

    initial
    begin
        sb = new();
        build_pool();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        directed_paths();
        random_paths();
        s_tvalid <= 1'b0;
        while (sb.replies_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d paths in %0d beats; %0d replies checked, %0d hits, %0d over-length.",
                 paths_sent, beats_sent, sb.replies_seen, sb.hits, sb.over_length);
        $display("Lookups %0d, replaces %0d, invalidates %0d, with one long output hold-off.",
                 sb.op_count[skdmc_pkg::FUNC_LOOKUP], sb.op_count[skdmc_pkg::FUNC_REPLACE],
                 sb.op_count[skdmc_pkg::FUNC_INVAL]);
        if (sb.errors == 0 && sb.replies_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/skdmc_pkg.sv
hw/rtl/string_keyed_direct_mapped_cache.sv
hw/rtl/skdmc_checker.sv
tb/tb.sv
